// ===== rtl/touch_event_generator_assert.svh =====
// Assertion macros shared by the touch event generator RTL.
// Needs nothing else; files that check their logic include this header.
`ifndef TOUCH_EVENT_GENERATOR_ASSERT_SVH
`define TOUCH_EVENT_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked property, disabled while reset is asserted
`define TEVG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tevg assertion failed");

// Condition that must never hold outside reset
`define TEVG_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tevg forbidden condition");

`else

`define TEVG_ASSERT(lbl, clk, rst_n, prop)
`define TEVG_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/tevg_pkg.sv =====
// Shared types and constants of the touch event generator.
// No dependencies; imported by every RTL module of the block.
package tevg_pkg;

	localparam int RAW_W     = 12;
	localparam int COEF_W    = 32;
	localparam int PX_W      = 9;
	localparam int PY_W      = 8;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 3;

	// event codes
	localparam logic [KIND_W-1:0] EV_NONE = 2'd0;
	localparam logic [KIND_W-1:0] EV_DOWN = 2'd1;
	localparam logic [KIND_W-1:0] EV_MOVE = 2'd2;
	localparam logic [KIND_W-1:0] EV_UP   = 2'd3;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_XO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_YO   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_VALID = 3'd6;

	// request entering the event stage
	typedef struct packed {
		logic vld;
		logic pressed;
	} tevg_ctl_t;

endpackage

// ===== rtl/tevg_axis_map.sv =====
// One axis of the affine map: two products, sum with offset, trunc and clamp.
// Depends on tevg_pkg; stage enables come from the top level.
module tevg_axis_map
	import tevg_pkg::*;
#(
	parameter int LIMIT = 320,
	parameter int OUT_W = 9
) (
	input  logic                     clk,
	input  logic                     en_s2,
	input  logic                     en_s3,
	input  logic [RAW_W-1:0]         ax_s1,
	input  logic [RAW_W-1:0]         ay_s1,
	input  logic signed [COEF_W-1:0] wr,
	input  logic signed [COEF_W-1:0] ws,
	input  logic signed [COEF_W-1:0] wo,
	output logic [OUT_W-1:0]         pos_s3
);

	localparam int PROD_W = COEF_W + RAW_W + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int Q_W    = SUM_W - 16;
	localparam logic [Q_W-1:0] LIM_M1 = Q_W'(LIMIT - 1);

	logic signed [PROD_W-1:0] pr_s2, ps_s2;
	logic signed [PROD_W-1:0] pr_d, ps_d;
	logic signed [SUM_W-1:0]  sum;
	logic [Q_W-1:0]           q;
	logic [OUT_W-1:0]         pos_d;

	assign pr_d = PROD_W'($signed(wr)) * PROD_W'($signed({1'b0, ax_s1}));
	assign ps_d = PROD_W'($signed(ws)) * PROD_W'($signed({1'b0, ay_s1}));

	always_ff @(posedge clk) begin
		if (en_s2) begin
			pr_s2 <= pr_d;
			ps_s2 <= ps_d;
		end
	end

	// negative sums are caught by the sign bit and clamp to 0
	assign sum = SUM_W'(pr_s2) + SUM_W'(ps_s2) + SUM_W'(wo);
	assign q   = sum[SUM_W-1:16];

	always_comb begin
		if (sum[SUM_W-1]) begin
			pos_d = '0;
		end else if (q > LIM_M1) begin
			pos_d = LIM_M1[OUT_W-1:0];
		end else begin
			pos_d = q[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			pos_s3 <= pos_d;
		end
	end

endmodule

// ===== rtl/tevg_event.sv =====
// Event decision, touch state and the result register.
// Depends on tevg_pkg and the assertion macro header.
`include "touch_event_generator_assert.svh"

module tevg_event
	import tevg_pkg::*;
#(
	parameter int MOVE_THRESHOLD = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tevg_ctl_t         ctl,
	input  logic [PX_W-1:0]   px,
	input  logic [PY_W-1:0]   py,
	input  logic              cal_valid,
	input  logic              out_stall,
	output logic              ld,
	output logic              out_valid,
	output logic [KIND_W-1:0] event_kind,
	output logic [PX_W-1:0]   event_x,
	output logic [PY_W-1:0]   event_y
);

	localparam logic [PX_W:0] THR = (PX_W+1)'(MOVE_THRESHOLD);

	logic              held_q;
	logic [PX_W-1:0]   last_px_q;
	logic [PY_W-1:0]   last_py_q;
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [PX_W-1:0]   x_q;
	logic [PY_W-1:0]   y_q;

	logic [PX_W-1:0]   dx;
	logic [PY_W-1:0]   dy;
	logic              moved;
	logic [KIND_W-1:0] kind_d;
	logic [PX_W-1:0]   x_d;
	logic [PY_W-1:0]   y_d;
	logic              held_d;
	logic              upd_last;

	assign ld = !out_valid_q || !out_stall;

	assign dx    = (px > last_px_q) ? px - last_px_q : last_px_q - px;
	assign dy    = (py > last_py_q) ? py - last_py_q : last_py_q - py;
	assign moved = ({1'b0, dx} > THR) || ({2'b00, dy} > THR);

	always_comb begin
		kind_d   = EV_NONE;
		x_d      = '0;
		y_d      = '0;
		held_d   = held_q;
		upd_last = 1'b0;
		if (cal_valid) begin
			if (ctl.pressed) begin
				held_d = 1'b1;
				if (!held_q || moved) begin
					kind_d   = held_q ? EV_MOVE : EV_DOWN;
					x_d      = px;
					y_d      = py;
					upd_last = 1'b1;
				end
			end else if (held_q) begin
				held_d = 1'b0;
				kind_d = EV_UP;
				x_d    = last_px_q;
				y_d    = last_py_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_q      <= 1'b0;
			last_px_q   <= '0;
			last_py_q   <= '0;
		end else if (ld) begin
			out_valid_q <= ctl.vld;
			if (ctl.vld) begin
				held_q <= held_d;
				if (upd_last) begin
					last_px_q <= px;
					last_py_q <= py;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld && ctl.vld) begin
			kind_q <= kind_d;
			x_q    <= x_d;
			y_q    <= y_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign event_x    = x_q;
	assign event_y    = y_q;

	`TEVG_ASSERT(a_up_uses_held_point, clk, arst_n, (ld && ctl.vld && cal_valid && !ctl.pressed && held_q) |=> (kind_q == EV_UP && x_q == $past(last_px_q) && y_q == $past(last_py_q)))
	`TEVG_ASSERT(a_press_sets_held, clk, arst_n, (ld && ctl.vld && cal_valid && ctl.pressed) |=> held_q)
	`TEVG_ASSERT(a_point_stored, clk, arst_n, (out_valid_q && (kind_q == EV_DOWN || kind_q == EV_MOVE)) |-> (last_px_q == x_q && last_py_q == y_q))
	`TEVG_NEVER(a_none_at_origin, clk, arst_n, out_valid_q && kind_q == EV_NONE && (x_q != '0 || y_q != '0))

endmodule

// ===== rtl/touch_event_generator.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_stall  | pressed, raw_x0..raw_x3, raw_y0..raw_y3
// out      | out_valid / out_stall| event_kind, event_x, event_y
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle while in_stall is low. Stages: s1 averages, s2
// multiplies (four 32x13), s3 sums/clamps, then the event stage updates touch
// state and loads the result register. Each stage loads when empty or when
// the next one advances, so bubbles collapse and a full result register only
// stalls input once all fill. arst_n clears stage valids, touch state and all
// config registers. cfg_ready is always high; the host must write only while
// no request is in flight, which the block itself does not enforce.
//
// Top level of the touch event generator; depends on tevg_pkg,
// tevg_axis_map and tevg_event.
module touch_event_generator
	import tevg_pkg::*;
#(
	parameter int SCREEN_WIDTH   = 320,
	parameter int SCREEN_HEIGHT  = 240,
	parameter int MOVE_THRESHOLD = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 pressed,
	input  logic [RAW_W-1:0]     raw_x0,
	input  logic [RAW_W-1:0]     raw_x1,
	input  logic [RAW_W-1:0]     raw_x2,
	input  logic [RAW_W-1:0]     raw_x3,
	input  logic [RAW_W-1:0]     raw_y0,
	input  logic [RAW_W-1:0]     raw_y1,
	input  logic [RAW_W-1:0]     raw_y2,
	input  logic [RAW_W-1:0]     raw_y3,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [KIND_W-1:0]    event_kind,
	output logic [PX_W-1:0]      event_x,
	output logic [PY_W-1:0]      event_y,
	// config write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	// calibration registers
	logic signed [COEF_W-1:0] coef_xr_q, coef_xs_q, coef_xo_q;
	logic signed [COEF_W-1:0] coef_yr_q, coef_ys_q, coef_yo_q;
	logic                     cal_valid_q;

	// pipeline valids and side data
	logic v_s1, v_s2, v_s3;
	logic pressed_s1, pressed_s2, pressed_s3;
	logic adv_1, adv_2, adv_3, adv_o;

	// averaged raw samples
	logic [RAW_W+1:0] sum_x, sum_y;
	logic [RAW_W-1:0] ax_s1, ay_s1;

	logic [PX_W-1:0] px_s3;
	logic [PY_W-1:0] py_s3;
	tevg_ctl_t       ev_ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xr_q   <= '0;
			coef_xs_q   <= '0;
			coef_xo_q   <= '0;
			coef_yr_q   <= '0;
			coef_ys_q   <= '0;
			coef_yo_q   <= '0;
			cal_valid_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COEF_XR:   coef_xr_q   <= cfg_data;
				REG_COEF_XS:   coef_xs_q   <= cfg_data;
				REG_COEF_XO:   coef_xo_q   <= cfg_data;
				REG_COEF_YR:   coef_yr_q   <= cfg_data;
				REG_COEF_YS:   coef_ys_q   <= cfg_data;
				REG_COEF_YO:   coef_yo_q   <= cfg_data;
				REG_CAL_VALID: cal_valid_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// backward advance chain: a stage loads when empty or when it drains
	assign adv_3    = !v_s3 || adv_o;
	assign adv_2    = !v_s2 || adv_3;
	assign adv_1    = !v_s1 || adv_2;
	assign in_stall = !adv_1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_1) v_s1 <= in_valid;
			if (adv_2) v_s2 <= v_s1;
			if (adv_3) v_s3 <= v_s2;
		end
	end

	// floor average of four samples
	assign sum_x = (RAW_W+2)'(raw_x0) + (RAW_W+2)'(raw_x1)
		+ (RAW_W+2)'(raw_x2) + (RAW_W+2)'(raw_x3);
	assign sum_y = (RAW_W+2)'(raw_y0) + (RAW_W+2)'(raw_y1)
		+ (RAW_W+2)'(raw_y2) + (RAW_W+2)'(raw_y3);

	always_ff @(posedge clk) begin
		if (adv_1) begin
			pressed_s1 <= pressed;
			ax_s1      <= sum_x[RAW_W+1:2];
			ay_s1      <= sum_y[RAW_W+1:2];
		end
		if (adv_2) pressed_s2 <= pressed_s1;
		if (adv_3) pressed_s3 <= pressed_s2;
	end

	tevg_axis_map #(
		.LIMIT (SCREEN_WIDTH),
		.OUT_W (PX_W)
	) u_map_x (
		.clk    (clk),
		.en_s2  (adv_2),
		.en_s3  (adv_3),
		.ax_s1  (ax_s1),
		.ay_s1  (ay_s1),
		.wr     (coef_xr_q),
		.ws     (coef_xs_q),
		.wo     (coef_xo_q),
		.pos_s3 (px_s3)
	);

	tevg_axis_map #(
		.LIMIT (SCREEN_HEIGHT),
		.OUT_W (PY_W)
	) u_map_y (
		.clk    (clk),
		.en_s2  (adv_2),
		.en_s3  (adv_3),
		.ax_s1  (ax_s1),
		.ay_s1  (ay_s1),
		.wr     (coef_yr_q),
		.ws     (coef_ys_q),
		.wo     (coef_yo_q),
		.pos_s3 (py_s3)
	);

	assign ev_ctl.vld     = v_s3;
	assign ev_ctl.pressed = pressed_s3;

	tevg_event #(
		.MOVE_THRESHOLD (MOVE_THRESHOLD)
	) u_event (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ev_ctl),
		.px         (px_s3),
		.py         (py_s3),
		.cal_valid  (cal_valid_q),
		.out_stall  (out_stall),
		.ld         (adv_o),
		.out_valid  (out_valid),
		.event_kind (event_kind),
		.event_x    (event_x),
		.event_y    (event_y)
	);

endmodule
